[hw/rtl/sst_pkg.sv]
// Shared types for the stack sorter: microcode word, step codes, actions, flags.
// The control ROM lives here as a function. No dependencies.
package sst_pkg;

  typedef enum logic [3:0] {
    STEP_IDLE        = 4'd0,
    STEP_POP_MAIN    = 4'd1,
    STEP_LOAD_HELD   = 4'd2,
    STEP_CMP_ISSUE   = 4'd3,
    STEP_CMP         = 4'd4,
    STEP_PUSH_AUX    = 4'd5,
    STEP_DRAIN_ISSUE = 4'd6,
    STEP_DRAIN_MOVE  = 4'd7,
    STEP_OUT_ISSUE   = 4'd8,
    STEP_OUT_EMIT    = 4'd9,
    STEP_CLEAR       = 4'd10
  } step_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_START_EOS,
    COND_MAIN_EMPTY,
    COND_AUX_EMPTY,
    COND_AUX_GT,
    COND_OUT_LAST
  } cond_e;

  typedef enum logic [1:0] {
    GATE_ALWAYS,
    GATE_TAKEN,
    GATE_NOT_TAKEN
  } gate_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_POP_MAIN,
    ACT_HELD,
    ACT_RD_AUX,
    ACT_MOVE,
    ACT_PUSH_AUX,
    ACT_RD_OUT,
    ACT_EMIT,
    ACT_CLEAR
  } act_e;

  typedef struct packed {
    cond_e cond;
    step_e jmp;   // target when condition holds
    step_e nxt;   // target otherwise
    act_e  act;
    gate_e gate;
  } ucode_t;

  typedef struct packed {
    logic main_empty;
    logic aux_empty;
    logic aux_gt;
    logic out_last;
  } flags_t;

  function automatic ucode_t ucode_rom(input step_e step);
    ucode_t w;
    w = '{cond: COND_ALWAYS, jmp: STEP_IDLE, nxt: STEP_IDLE, act: ACT_NONE, gate: GATE_ALWAYS};
    case (step)
      STEP_IDLE: begin
        w = '{COND_START_EOS, STEP_POP_MAIN, STEP_IDLE, ACT_LOAD, GATE_ALWAYS};
      end
      STEP_POP_MAIN: begin
        w = '{COND_MAIN_EMPTY, STEP_DRAIN_ISSUE, STEP_LOAD_HELD, ACT_POP_MAIN, GATE_NOT_TAKEN};
      end
      STEP_LOAD_HELD: begin
        w = '{COND_ALWAYS, STEP_CMP_ISSUE, STEP_CMP_ISSUE, ACT_HELD, GATE_ALWAYS};
      end
      STEP_CMP_ISSUE: begin
        w = '{COND_AUX_EMPTY, STEP_PUSH_AUX, STEP_CMP, ACT_RD_AUX, GATE_NOT_TAKEN};
      end
      STEP_CMP: begin
        w = '{COND_AUX_GT, STEP_CMP_ISSUE, STEP_PUSH_AUX, ACT_MOVE, GATE_TAKEN};
      end
      STEP_PUSH_AUX: begin
        w = '{COND_ALWAYS, STEP_POP_MAIN, STEP_POP_MAIN, ACT_PUSH_AUX, GATE_ALWAYS};
      end
      STEP_DRAIN_ISSUE: begin
        w = '{COND_AUX_EMPTY, STEP_OUT_ISSUE, STEP_DRAIN_MOVE, ACT_RD_AUX, GATE_NOT_TAKEN};
      end
      STEP_DRAIN_MOVE: begin
        w = '{COND_ALWAYS, STEP_DRAIN_ISSUE, STEP_DRAIN_ISSUE, ACT_MOVE, GATE_ALWAYS};
      end
      STEP_OUT_ISSUE: begin
        w = '{COND_MAIN_EMPTY, STEP_CLEAR, STEP_OUT_EMIT, ACT_RD_OUT, GATE_NOT_TAKEN};
      end
      STEP_OUT_EMIT: begin
        w = '{COND_OUT_LAST, STEP_CLEAR, STEP_OUT_ISSUE, ACT_EMIT, GATE_ALWAYS};
      end
      STEP_CLEAR: begin
        w = '{COND_ALWAYS, STEP_IDLE, STEP_IDLE, ACT_CLEAR, GATE_ALWAYS};
      end
      default: begin
        w = '{COND_ALWAYS, STEP_IDLE, STEP_IDLE, ACT_NONE, GATE_ALWAYS};
      end
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/stack_sort_with_aux_stack.sv]
// Stack sorter, top level: sequencer plus datapath.
// Depends on sst_pkg, sst_useq, sst_datapath (and sst_ram below it).
//
// Values are pushed on a main stack, one beat per cycle, whenever start_i is
// high and busy_o is low; a push onto a full stack is dropped. The beat with
// end_of_set_i high is pushed like the others and then starts the sort, and
// busy_o stays high until the whole sorted run has gone out. The sort pops
// each value off the main stack, moves every larger aux entry back to the main
// stack, then pushes the value on the aux stack; finally the aux stack drains
// back. Each stack is one RAM with a registered read, so every examined aux
// entry takes an issue step and then a compare or move step, besides the pop,
// load-held and push steps of each popped value. Every value moved back is
// popped again. Each drained entry takes an issue and a move step, each result
// an issue and an emit step, and a clear step ends the run. Results come out
// largest first, each on sorted_value_o for exactly one cycle with out_strobe_o
// high and last_of_run_o high on the final one. The receiver cannot stall: it
// must take every beat as it appears.
module stack_sort_with_aux_stack #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] value_i,
  input  logic               end_of_set_i,
  output logic               out_strobe_o,
  output logic signed [31:0] sorted_value_o,
  output logic               last_of_run_o
);
  import sst_pkg::*;

  act_e   act;
  flags_t flags;

  // control program: step counter plus ROM
  sst_useq u_useq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .end_of_set_i (end_of_set_i),
    .flags_i      (flags),
    .act_o        (act),
    .busy_o       (busy_o)
  );

  // stacks, pointers and compare
  sst_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .act_i          (act),
    .start_i        (start_i),
    .value_i        (value_i),
    .flags_o        (flags),
    .out_strobe_o   (out_strobe_o),
    .sorted_value_o (sorted_value_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

[hw/rtl/sst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/sst_useq.sv]
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on sst_pkg.
module sst_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            end_of_set_i,
  input  sst_pkg::flags_t flags_i,
  output sst_pkg::act_e   act_o,
  output logic            busy_o
);
  import sst_pkg::*;

  step_e  step_q, step_d;
  ucode_t word;
  logic   taken;

  assign word = ucode_rom(step_q);

  always_comb begin
    case (word.cond)
      COND_ALWAYS:     taken = 1'b1;
      COND_START_EOS:  taken = start_i & end_of_set_i;
      COND_MAIN_EMPTY: taken = flags_i.main_empty;
      COND_AUX_EMPTY:  taken = flags_i.aux_empty;
      COND_AUX_GT:     taken = flags_i.aux_gt;
      COND_OUT_LAST:   taken = flags_i.out_last;
      default:         taken = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    step_d = taken ? word.jmp : word.nxt;
  end

  // outputs
  always_comb begin
    case (word.gate)
      GATE_ALWAYS:    act_o = word.act;
      GATE_TAKEN:     act_o = taken ? word.act : ACT_NONE;
      GATE_NOT_TAKEN: act_o = taken ? ACT_NONE : word.act;
      default:        act_o = ACT_NONE;
    endcase
    busy_o = (step_q != STEP_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

[hw/rtl/sst_datapath.sv]
// Datapath: main and aux stack RAMs, stack pointers, held value, output index.
// Depends on sst_pkg and sst_ram.
module sst_datapath #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sst_pkg::act_e      act_i,
  input  logic               start_i,
  input  logic signed [31:0] value_i,
  output sst_pkg::flags_t    flags_o,
  output logic               out_strobe_o,
  output logic signed [31:0] sorted_value_o,
  output logic               last_of_run_o
);
  import sst_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0] main_cnt_q, main_cnt_d;
  logic [CW-1:0] aux_cnt_q, aux_cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [31:0]   held_q;
  logic [CW-1:0] main_top, aux_top;

  logic          load, full;
  logic          main_we, aux_we;
  logic [AW-1:0] main_raddr;
  logic [31:0]   main_wdata, main_rdata, aux_rdata;

  assign full     = (main_cnt_q == CW'(STACK_DEPTH));
  assign load     = (act_i == ACT_LOAD) && start_i && !full;
  assign main_top = main_cnt_q - CW'(1);
  assign aux_top  = aux_cnt_q - CW'(1);

  assign main_we    = load || (act_i == ACT_MOVE);
  assign main_wdata = load ? value_i : aux_rdata;
  assign main_raddr = (act_i == ACT_RD_OUT) ? idx_q[AW-1:0] : main_top[AW-1:0];
  assign aux_we     = (act_i == ACT_PUSH_AUX);

  sst_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (main_we),
    .waddr_i (main_cnt_q[AW-1:0]),
    .wdata_i (main_wdata),
    .raddr_i (main_raddr),
    .rdata_o (main_rdata)
  );

  sst_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_aux_ram (
    .clk_i   (clk_i),
    .we_i    (aux_we),
    .waddr_i (aux_cnt_q[AW-1:0]),
    .wdata_i (held_q),
    .raddr_i (aux_top[AW-1:0]),
    .rdata_o (aux_rdata)
  );

  always_comb begin
    main_cnt_d = main_cnt_q;
    aux_cnt_d  = aux_cnt_q;
    idx_d      = idx_q;
    case (act_i)
      ACT_LOAD:     if (load) main_cnt_d = main_cnt_q + CW'(1);
      ACT_POP_MAIN: main_cnt_d = main_top;
      ACT_MOVE: begin
        main_cnt_d = main_cnt_q + CW'(1);
        aux_cnt_d  = aux_top;
      end
      ACT_PUSH_AUX: aux_cnt_d = aux_cnt_q + CW'(1);
      ACT_RD_OUT:   idx_d = idx_q + CW'(1);
      ACT_CLEAR: begin
        main_cnt_d = '0;
        aux_cnt_d  = '0;
        idx_d      = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_cnt_q <= '0;
      aux_cnt_q  <= '0;
      idx_q      <= '0;
    end else begin
      main_cnt_q <= main_cnt_d;
      aux_cnt_q  <= aux_cnt_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_i == ACT_HELD) begin
      held_q <= main_rdata;
    end
  end

  assign flags_o.main_empty = (main_cnt_q == '0);
  assign flags_o.aux_empty  = (aux_cnt_q == '0);
  assign flags_o.aux_gt     = ($signed(aux_rdata) > $signed(held_q));
  assign flags_o.out_last   = (idx_q == main_cnt_q);

  assign out_strobe_o   = (act_i == ACT_EMIT);
  assign sorted_value_o = main_rdata;
  assign last_of_run_o  = flags_o.out_last;

endmodule

[tb/testbench.sv]
// Self-checking bench for stack_sort_with_aux_stack: directed table, then random sets.
// Depends on the RTL top stack_sort_with_aux_stack (and, through it, sst_pkg).
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  // One sorted beat as it leaves the block.
  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } sorted_beat_t;

  // Directed stimulus row. When has_want is set, the set is a single value and
  // the one beat it yields is typed in here; otherwise the predictor decides.
  typedef struct packed {
    logic signed [31:0] value;
    logic               eos;
    logic               has_want;
    logic signed [31:0] want;
  } row_t;

  localparam int NROWS = 21;
  localparam row_t ROWS [NROWS] = '{
    // single-value sets: both extremes, zero and minus one
    '{MAXV,            1'b1, 1'b1, MAXV},
    '{MINV,            1'b1, 1'b1, MINV},
    '{32'sd0,          1'b1, 1'b1, 32'sd0},
    '{-32'sd1,         1'b1, 1'b1, -32'sd1},
    // mixed signs, duplicates, both extremes in one set
    '{32'sd5,          1'b0, 1'b0, 32'sd0},
    '{-32'sd3,         1'b0, 1'b0, 32'sd0},
    '{32'sd5,          1'b0, 1'b0, 32'sd0},
    '{MINV,            1'b0, 1'b0, 32'sd0},
    '{MAXV,            1'b0, 1'b0, 32'sd0},
    '{32'sd0,          1'b1, 1'b0, 32'sd0},
    // already ascending on the stack
    '{32'sd1,          1'b0, 1'b0, 32'sd0},
    '{32'sd2,          1'b0, 1'b0, 32'sd0},
    '{32'sd3,          1'b1, 1'b0, 32'sd0},
    // already descending on the stack
    '{32'sd3,          1'b0, 1'b0, 32'sd0},
    '{32'sd2,          1'b0, 1'b0, 32'sd0},
    '{32'sd1,          1'b1, 1'b0, 32'sd0},
    // all equal
    '{32'sd7,          1'b0, 1'b0, 32'sd0},
    '{32'sd7,          1'b0, 1'b0, 32'sd0},
    '{32'sd7,          1'b1, 1'b0, 32'sd0},
    // alternating bit patterns
    '{32'sh5555_5555,  1'b0, 1'b0, 32'sd0},
    '{32'shaaaa_aaaa,  1'b1, 1'b0, 32'sd0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic signed [31:0] value_i;
  logic               end_of_set_i;
  logic               out_strobe_o;
  logic signed [31:0] sorted_value_o;
  logic               last_of_run_o;

  // Predictor state: both stacks at the block's widths.
  logic signed [31:0] main_stk [DEPTH];
  int                 main_cnt;
  logic signed [31:0] aux_stk [DEPTH];
  int                 aux_cnt;

  sorted_beat_t sorted_q [$];   // beats still owed by the block, oldest first
  sorted_beat_t run_q [$];      // run produced by the latest beat, empty unless it ended a set
  int           err_cnt = 0;
  bit           gaps_on = 1'b1;

  stack_sort_with_aux_stack #(
    .STACK_DEPTH(DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .end_of_set_i  (end_of_set_i),
    .out_strobe_o  (out_strobe_o),
    .sorted_value_o(sorted_value_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Push one value (dropped when the main stack is full). On end of set, run
  // the stack sort: pop each value, move larger aux entries back to main, push
  // it on aux; then drain aux onto main. Main then reads descending bottom-up.
  task automatic push_and_sort(input logic signed [31:0] v, input logic eos);
    logic signed [31:0] held;
    run_q.delete();
    if (main_cnt < DEPTH) begin
      main_stk[main_cnt] = v;
      main_cnt++;
    end
    if (eos) begin
      while (main_cnt > 0) begin
        main_cnt--;
        held = main_stk[main_cnt];
        while (aux_cnt > 0 && aux_stk[aux_cnt-1] > held) begin
          aux_cnt--;
          if (main_cnt < DEPTH) begin
            main_stk[main_cnt] = aux_stk[aux_cnt];
            main_cnt++;
          end
        end
        if (aux_cnt < DEPTH) begin
          aux_stk[aux_cnt] = held;
          aux_cnt++;
        end
      end
      while (aux_cnt > 0) begin
        aux_cnt--;
        main_stk[main_cnt] = aux_stk[aux_cnt];
        main_cnt++;
      end
      for (int i = 0; i < main_cnt; i++) begin
        run_q.push_back('{value: main_stk[i], last: (i == main_cnt - 1)});
      end
      main_cnt = 0;
      aux_cnt  = 0;
    end
  endtask

  // Drive one beat and hold it until accepted (start high, busy low at an
  // edge). Random idle cycles go in front; value and flag carry junk then.
  task automatic drive_beat(input logic signed [31:0] v, input logic eos);
    while (gaps_on && $urandom_range(0, 99) < 20) begin
      start_i      <= 1'b0;
      value_i      <= $urandom;
      end_of_set_i <= 1'($urandom_range(0, 1));
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    value_i      <= v;
    end_of_set_i <= eos;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Mix of extremes, near-zero values (plenty of duplicates) and full range.
  function automatic logic signed [31:0] rand_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 7))
      0:       v = MAXV;
      1:       v = MINV;
      2:       v = $signed($urandom_range(0, 16)) - 32'sd8;
      3:       v = $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Output checker: the receiver never stalls, so every strobe is a beat.
  always @(posedge clk_i) begin
    sorted_beat_t exp_beat;
    if (rst_ni && out_strobe_o) begin
      if (sorted_q.size() == 0) begin
        $error("unexpected beat: sorted_value=%0d last_of_run=%0b",
               sorted_value_o, last_of_run_o);
        err_cnt++;
      end else begin
        exp_beat = sorted_q.pop_front();
        if (sorted_value_o !== exp_beat.value) begin
          $error("sorted_value: expected %0d, actual %0d", exp_beat.value, sorted_value_o);
          err_cnt++;
        end
        if (last_of_run_o !== exp_beat.last) begin
          $error("last_of_run: expected %0b, actual %0b", exp_beat.last, last_of_run_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int n_items;
    int set_len;
    int r;
    int drain_wait;
    logic signed [31:0] v;
    logic               eos;

    main_cnt     = 0;
    aux_cnt      = 0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    value_i      = '0;
    end_of_set_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (int i = 0; i < NROWS; i++) begin
      drive_beat(ROWS[i].value, ROWS[i].eos);
      push_and_sort(ROWS[i].value, ROWS[i].eos);
      if (ROWS[i].has_want) begin
        sorted_q.push_back('{value: ROWS[i].want, last: 1'b1});
      end else begin
        foreach (run_q[j]) sorted_q.push_back(run_q[j]);
      end
    end

    // Random sets, each closed by an end-of-set beat. The first one overruns
    // the stack so even the closing value gets dropped; later ones overrun
    // now and then. Items 40..89 run without idle cycles.
    n_items = 0;
    set_len = 66;
    while (n_items < 130) begin
      for (int k = 0; k < set_len; k++) begin
        gaps_on = !(n_items >= 40 && n_items < 90);
        v   = rand_value();
        eos = (k == set_len - 1);
        drive_beat(v, eos);
        push_and_sort(v, eos);
        foreach (run_q[j]) sorted_q.push_back(run_q[j]);
        n_items++;
      end
      r = $urandom_range(0, 99);
      if (r < 6)       set_len = $urandom_range(60, 70);
      else if (r < 15) set_len = 1;
      else             set_len = $urandom_range(2, 12);
    end
    start_i <= 1'b0;

    // Let the last run drain, then wait out the clear step.
    drain_wait = 0;
    while (sorted_q.size() != 0 && drain_wait < 20000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (20) @(posedge clk_i);

    if (err_cnt == 0 && sorted_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (sorted_q.size() != 0) $error("%0d sorted beats never arrived", sorted_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[stack_sort_with_aux_stack.f]
hw/rtl/sst_pkg.sv
hw/rtl/sst_ram.sv
hw/rtl/sst_useq.sv
hw/rtl/sst_datapath.sv
hw/rtl/stack_sort_with_aux_stack.sv
tb/testbench.sv
